>>> sv/stsu_pkg.sv
// ============================================================================
// stsu_pkg - shared types and constants of the sine tone synthesizer
// Word formats, register indexes and the quarter-wave sine table generator.
// ============================================================================
package stsu_pkg;

    // Phase accumulator and table geometry
    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int QUARTER_N       = 1 << TABLE_ADDR_BITS;
    localparam int ROM_ADDR_W      = TABLE_ADDR_BITS + 1;

    // Field and register widths
    localparam int STEP_W   = 32;
    localparam int GAIN_W   = 16;
    localparam int MAG_W    = 15;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = MAG_W + GAIN_W;
    localparam int CFG_W    = 32;

    // Output queue that decouples the two handshakes
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(32768);
    localparam logic [63:0]       FULL_SCALE = 64'd32767;
    localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;

    // Taylor series denominators (2k)(2k+1) for k = 1..19
    localparam logic [11:0] TAYLOR_DEN [1:19] = '{
        12'd6,   12'd20,  12'd42,  12'd72,  12'd110, 12'd156, 12'd210,
        12'd272, 12'd342, 12'd420, 12'd506, 12'd600, 12'd702, 12'd812,
        12'd930, 12'd1056, 12'd1190, 12'd1332, 12'd1482
    };

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_PHASE_STEP = 1'b0,
        CFG_AMPLITUDE  = 1'b1
    } t_cfg_index;

    // Input word: one sample request
    typedef struct packed {
        logic restart_phase;
        logic end_of_block;
    } t_in_word;

    // Output word: one sine sample
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } t_out_word;

    typedef logic [MAG_W-1:0] t_qtab [0:QUARTER_N];

    // Build the quarter-wave table: Q30 Taylor series of sin, rounded half up
    function automatic t_qtab stsu_qtab();
        t_qtab       tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] v;
        for (int i = 0; i < QUARTER_N; i++) begin
            x    = (HALF_PI_Q30 * 64'(i)) >> TABLE_ADDR_BITS;
            x2   = (x * x) >> 30;
            term = x;
            pos  = x;
            neg  = 64'd0;
            for (int k = 1; k < 20; k++) begin
                term = ((term * x2) >> 30) / 64'(TAYLOR_DEN[k]);
                if ((k & 1) != 0) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
            v = (pos > neg) ? pos - neg : 64'd0;
            v = (v * FULL_SCALE + (64'd1 << 29)) >> 30;
            if (v > FULL_SCALE) begin
                v = FULL_SCALE;
            end
            tab[i] = MAG_W'(v);
        end
        tab[QUARTER_N] = MAG_W'(FULL_SCALE);
        return tab;
    endfunction

endpackage

>>> sv/sine_tone_synthesizer_unit.sv
// ============================================================================
// sine_tone_synthesizer_unit - direct digital synthesis sine oscillator
// Phase accumulator, quarter-wave sine ROM, gain multiply and output queue.
// ============================================================================
//
//  channel  | direction | handshake            | word
//  ---------+-----------+----------------------+-------------------------------
//  in       | into unit | i_in_valid/o_in_stall | restart_phase, end_of_block
//  out      | from unit | o_out_valid/i_out_stall | sample, last_sample
//  cfg      | into unit | i_cfg_wr_en          | index 0 phase_step, 1 amplitude
//
//  One word per cycle sustained while o_in_stall is low. The phase add and ROM
//  address are formed in the accept cycle, the ROM read is registered, then the
//  gain multiply, then sign and queue write. A 4-entry output queue absorbs
//  downstream stalls; o_in_stall rises when 4 words are accepted and not yet
//  delivered.
//
module sine_tone_synthesizer_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  stsu_pkg::t_in_word     i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output stsu_pkg::t_out_word    o_out_word,
    input  logic                   i_cfg_wr_en,
    input  stsu_pkg::t_cfg_index   i_cfg_index,
    input  logic [stsu_pkg::CFG_W-1:0] i_cfg_wdata
);
    import stsu_pkg::*;

    localparam int ACC_W = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;
    localparam int TOP_W = TABLE_ADDR_BITS + 2;

    // Quarter-wave sine ROM
    localparam t_qtab QTAB = stsu_qtab();

    // Configuration
    logic [STEP_W-1:0]     r_step;
    logic [GAIN_W-1:0]     r_gain;
    logic [GAIN_W-1:0]     w_gain_wr;

    // Phase
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic [PHASE_BITS-1:0] w_phase_use;
    logic [ACC_W-1:0]      w_phase_sum;
    logic [TOP_W-1:0]      w_top;
    logic [ROM_ADDR_W-1:0] w_rom_addr;

    // Pipeline
    logic                  w_in_acc;
    logic                  w_out_acc;
    logic                  r_s1_valid;
    logic [MAG_W-1:0]      r_s1_mag;
    logic                  r_s1_neg;
    logic                  r_s1_last;
    logic [PROD_W-1:0]     w_prod;
    logic                  r_s2_valid;
    logic [MAG_W-1:0]      r_s2_scaled;
    logic                  r_s2_neg;
    logic                  r_s2_last;
    t_out_word             w_oq_wr;

    // Output queue
    t_out_word             r_oq [0:OQ_DEPTH-1];
    logic [OQ_PTR_W-1:0]   r_oq_wr_ptr;
    logic [OQ_PTR_W-1:0]   r_oq_rd_ptr;
    logic [OQ_CNT_W-1:0]   r_oq_cnt;
    logic [OQ_CNT_W-1:0]   r_pending;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_oq_cnt != '0);
    assign w_out_acc   = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_pending == OQ_CNT_W'(OQ_DEPTH));
    assign o_out_word  = r_oq[r_oq_rd_ptr];

    // Clamp the gain to full scale as it is written
    assign w_gain_wr = (i_cfg_wdata[GAIN_W-1:0] > GAIN_ONE) ? GAIN_ONE
                                                             : i_cfg_wdata[GAIN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_gain <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PHASE_STEP: r_step <= i_cfg_wdata[STEP_W-1:0];
                CFG_AMPLITUDE:  r_gain <= w_gain_wr;
                default:        r_step <= r_step;
            endcase
        end
    end

    // Restart clears the phase before the sample; advance after it
    always_comb begin
        w_phase_use = i_in_word.restart_phase ? '0 : r_phase;
        w_phase_sum = ACC_W'(w_phase_use) + ACC_W'(r_step);
        n_phase     = w_in_acc ? w_phase_sum[PHASE_BITS-1:0] : r_phase;
        w_top       = w_phase_use[PHASE_BITS-1 -: TOP_W];
        w_rom_addr  = w_top[TABLE_ADDR_BITS] ?
                      ROM_ADDR_W'(QUARTER_N) - {1'b0, w_top[TABLE_ADDR_BITS-1:0]} :
                      {1'b0, w_top[TABLE_ADDR_BITS-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Stage 1: registered ROM read
    always_ff @(posedge i_clk) begin
        r_s1_mag  <= QTAB[w_rom_addr];
        r_s1_neg  <= w_top[TOP_W-1];
        r_s1_last <= i_in_word.end_of_block;
    end

    // Stage 2: gain multiply, truncate toward zero
    assign w_prod = PROD_W'(r_s1_mag) * PROD_W'(r_gain);

    always_ff @(posedge i_clk) begin
        r_s2_scaled <= w_prod[MAG_W+14:15];
        r_s2_neg    <= r_s1_neg;
        r_s2_last   <= r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_acc;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Apply the quadrant sign
    always_comb begin
        w_oq_wr.sample      = r_s2_neg ? SAMPLE_W'(0) - SAMPLE_W'(r_s2_scaled)
                                       : SAMPLE_W'(r_s2_scaled);
        w_oq_wr.last_sample = r_s2_last;
    end

    // Output queue storage
    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_oq[r_oq_wr_ptr] <= w_oq_wr;
        end
    end

    // Queue pointers, fill count and words in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr_ptr <= '0;
            r_oq_rd_ptr <= '0;
            r_oq_cnt    <= '0;
            r_pending   <= '0;
        end else begin
            if (r_s2_valid) begin
                r_oq_wr_ptr <= r_oq_wr_ptr + 1'b1;
            end
            if (w_out_acc) begin
                r_oq_rd_ptr <= r_oq_rd_ptr + 1'b1;
            end
            r_oq_cnt  <= r_oq_cnt + OQ_CNT_W'(r_s2_valid) - OQ_CNT_W'(w_out_acc);
            r_pending <= r_pending + OQ_CNT_W'(w_in_acc) - OQ_CNT_W'(w_out_acc);
        end
    end

endmodule

>>> sv/stsu_checker.sv
// ============================================================================
// stsu_checker - port-level checks for the sine tone synthesizer
// Watches both channels and flags ordering and flow-control slips.
// ============================================================================
module stsu_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   o_in_stall,
    input  logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  stsu_pkg::t_out_word    o_out_word
);
    import stsu_pkg::*;

    logic       w_in_acc;
    logic       w_out_acc;
    logic [7:0] r_open;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;

    // Count words accepted and not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + 8'(w_in_acc) - 8'(w_out_acc);
        end
    end

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    // Deliver nothing that was not requested
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> (r_open != 8'd0))
        else $error("output word without a pending request");

    // A full unit always has a finished word to offer
    a_full_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled while no output is offered");

    // Every accepted request is followed by an offered output word
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> ##3 o_out_valid)
        else $error("sample missing three cycles after request");

    // Never more words in flight than the output queue can hold
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= 8'(OQ_DEPTH))
        else $error("more words in flight than the queue holds");

endmodule

bind sine_tone_synthesizer_unit stsu_checker u_stsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
